[src/sfc_pkg.sv]
// Shared types, constants and the CRC-8 function of the serial frame checker.
package sfc_pkg;

	localparam logic [7:0] SYNC_VALUE = 8'h55;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam int         TOTAL_W    = 17;
	localparam int         TDATA_W    = 40;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_BAD_HCRC = 2'd2,
		ST_BAD_DCRC = 2'd3
	} status_t;

	typedef struct packed {
		logic               last;
		logic [7:0]         payload_byte;
		status_t            frame_status;
		logic [7:0]         packet_type;
		logic [TOTAL_W-1:0] total_length;
	} out_item_t;

	// MSB-first CRC-8, no reflection, no final XOR.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[src/sfc_parser.sv]
// Packet parser: frame state and the per-byte step that yields at most one result.
module sfc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output sfc_pkg::out_item_t res_item
);
	import sfc_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_HCRC    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_DCRC    = 3'd4
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [1:0]         hdr_idx_q, hdr_idx_n;
	logic [7:0]         crc_q, crc_n;
	logic [15:0]        dlen_q, dlen_n;
	logic [7:0]         olen_q, olen_n;
	logic [7:0]         type_q, type_n;
	logic [TOTAL_W-1:0] left_q, left_n;
	logic [TOTAL_W-1:0] total;

	assign total = {1'b0, dlen_q} + {{(TOTAL_W-8){1'b0}}, olen_q};

	always_comb begin
		phase_n   = phase_q;
		hdr_idx_n = hdr_idx_q;
		crc_n     = crc_q;
		dlen_n    = dlen_q;
		olen_n    = olen_q;
		type_n    = type_q;
		left_n    = left_q;
		res_valid = 1'b0;
		res_item.last         = 1'b1;
		res_item.payload_byte = 8'd0;
		res_item.frame_status = ST_OK;
		res_item.packet_type  = type_q;
		res_item.total_length = total;

		unique case (phase_q)
			PH_HEADER: begin
				crc_n = crc8_update(crc_q, rx_byte);
				unique case (hdr_idx_q)
					2'd0: dlen_n = {rx_byte, dlen_q[7:0]};
					2'd1: dlen_n = {dlen_q[15:8], rx_byte};
					2'd2: olen_n = rx_byte;
					default: type_n = rx_byte;
				endcase
				if (hdr_idx_q == 2'd3) begin
					hdr_idx_n = 2'd0;
					phase_n   = PH_HCRC;
				end else begin
					hdr_idx_n = hdr_idx_q + 2'd1;
				end
			end
			PH_HCRC: begin
				if (dlen_q == 16'd0 && olen_q == 8'd0) begin
					res_valid             = 1'b1;
					res_item.frame_status = ST_ZERO_LEN;
				end else if (rx_byte != crc_q) begin
					res_valid             = 1'b1;
					res_item.frame_status = ST_BAD_HCRC;
				end else begin
					crc_n   = 8'd0;
					left_n  = total;
					phase_n = PH_PAYLOAD;
				end
				if (res_valid) begin
					phase_n   = PH_HUNT;
					hdr_idx_n = 2'd0;
					crc_n     = 8'd0;
				end
			end
			PH_PAYLOAD: begin
				crc_n  = crc8_update(crc_q, rx_byte);
				left_n = left_q - {{(TOTAL_W-1){1'b0}}, 1'b1};
				if (left_n == '0) begin
					phase_n = PH_DCRC;
				end
				res_valid             = 1'b1;
				res_item.last         = 1'b0;
				res_item.payload_byte = rx_byte;
			end
			PH_DCRC: begin
				res_valid             = 1'b1;
				res_item.frame_status = (rx_byte == crc_q) ? ST_OK : ST_BAD_DCRC;
				phase_n               = PH_HUNT;
				hdr_idx_n             = 2'd0;
				crc_n                 = 8'd0;
			end
			default: begin
				// Hunting, also for unused codes: the sync byte starts a header, any other byte keeps hunting.
				if (rx_byte == SYNC_VALUE) begin
					phase_n   = PH_HEADER;
					hdr_idx_n = 2'd0;
					crc_n     = 8'd0;
				end else begin
					phase_n = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_idx_q <= 2'd0;
			crc_q     <= 8'd0;
			dlen_q    <= 16'd0;
			olen_q    <= 8'd0;
			type_q    <= 8'd0;
			left_q    <= '0;
		end else if (step_en) begin
			phase_q   <= phase_n;
			hdr_idx_q <= hdr_idx_n;
			crc_q     <= crc_n;
			dlen_q    <= dlen_n;
			olen_q    <= olen_n;
			type_q    <= type_n;
			left_q    <= left_n;
		end
	end

endmodule

[src/sfc_out_buf.sv]
// Two-entry result buffer between the parser and the output stream.
module sfc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sfc_pkg::out_item_t wr_item,
	input  logic              rd_en,
	output logic              rd_valid,
	output sfc_pkg::out_item_t rd_item,
	output logic              full
);
	import sfc_pkg::*;

	out_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rd_valid = (count_q != 2'd0);
	assign full     = (count_q == 2'd2);
	assign rd_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/serial_frame_checker_crc8.sv]
// Top level of the serial frame checker: input register, parser and result buffer.
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------------
//  s_*     | in        | s_tdata[7:0] rx_byte
//  m_*     | out       | m_tdata: payload_byte, frame_status, packet_type,
//          |           |   total_length; m_tlast marks an end-of-packet status
//
// Each request is taken into an input register. The parser handles it and writes
// at most one result into a two-entry output buffer. One request per cycle is
// sustained; a result passes through the input register and then the output buffer,
// which drives m_tvalid. The input side stalls only while the buffer holds two
// results, which follows m_tready having been held low. Reset is asynchronous and
// returns the parser to hunting for the sync byte with an empty buffer.
module serial_frame_checker_crc8 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfc_pkg::TDATA_W-1:0]   m_tdata,  // [7:0] payload_byte, [9:8] frame_status,
	                                                // [17:10] packet_type, [34:18] total_length,
	                                                // [39:35] zero
	output logic                          m_tlast   // item_kind: 1 for an end-of-packet status
);
	import sfc_pkg::*;

	// Input register holding one received byte.
	logic       valid_s1;
	logic [7:0] byte_s1;

	logic       advance;
	logic       step_en;
	logic       res_valid;
	out_item_t  res_item;
	logic       buf_wr;
	logic       buf_rd;
	logic       buf_full;
	out_item_t  out_item;

	// The buffer full flag is registered, so the input side never waits on
	// m_tready combinationally.
	assign advance  = !buf_full;
	assign step_en  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sfc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	assign buf_wr = step_en && res_valid;
	assign buf_rd = m_tvalid && m_tready;

	sfc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (buf_wr),
		.wr_item  (res_item),
		.rd_en    (buf_rd),
		.rd_valid (m_tvalid),
		.rd_item  (out_item),
		.full     (buf_full)
	);

	// Fields are packed from the lowest bit up; the top bits pad to whole bytes.
	assign m_tdata = {{(TDATA_W-35){1'b0}}, out_item.total_length, out_item.packet_type,
	                  out_item.frame_status, out_item.payload_byte};
	assign m_tlast = out_item.last;

`ifndef NO_ASSERTIONS
	// A result is never written into a full buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr |-> !buf_full)
		else $error("result written into full output buffer");

	// The input side only stalls while a byte is waiting in the input register.
	a_stall_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input register");

	// Payload items always carry an ok status.
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[9:8] == ST_OK))
		else $error("payload item with non-ok status");

	// Status items carry a zero payload byte.
	a_status_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'd0))
		else $error("status item with nonzero payload byte");
`endif

endmodule
